>>> hdl/nms_pkg.sv
package nms_pkg;

  // Node management states
  typedef enum logic [3:0] {
    ST_NORM_OFFLINE = 4'd0,
    ST_NORM_ONLINE  = 4'd1,
    ST_NORM_LIST    = 4'd2,
    ST_NORM_INIT    = 4'd3,
    ST_BPGM_OFFLINE = 4'd4,
    ST_BPGM_START   = 4'd5,
    ST_BPGM_DATA    = 4'd6,
    ST_BPGM_END     = 4'd7,
    ST_BPGM_COPY    = 4'd8,
    ST_APGM_OFFLINE = 4'd9,
    ST_APGM_START   = 4'd10,
    ST_APGM_DATA    = 4'd11,
    ST_APGM_END     = 4'd12
  } node_state_e;

  // Bus event codes
  typedef enum logic [3:0] {
    EV_BIOS_START = 4'd0,
    EV_APP_START  = 4'd1,
    EV_HEARTBEAT  = 4'd2,
    EV_LIST_DONE  = 4'd3,
    EV_PGM_BIOS   = 4'd4,
    EV_PGM_APP    = 4'd5,
    EV_RESET      = 4'd6,
    EV_ACK        = 4'd7,
    EV_NACK       = 4'd8
  } event_e;

  // Command issued towards the node
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_LIST  = 2'd2
  } cmd_e;

  // Request kind
  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_NODE_ID = 1'b1;

  localparam logic [7:0] TIMEOUT_RESET = 8'd10;

  // Transition table codes beside the real states
  localparam logic [3:0] T_KEEP     = 4'd14;
  localparam logic [3:0] T_NO_ENTRY = 4'd15;

  typedef struct packed {
    logic       action;
    logic [3:0] event_code;
  } nms_in_t;

  typedef struct packed {
    node_state_e new_state;
    node_state_e old_state;
    logic        state_changed;
    cmd_e        command;
    logic        no_transition;
    logic        timed_out;
    logic [31:0] command_node;
  } nms_out_t;

  // Fixed transition table: next state, T_KEEP or T_NO_ENTRY
  function automatic logic [3:0] nms_lookup(input node_state_e st, input logic [3:0] ev);
    logic [3:0] t;
    t = T_NO_ENTRY;
    case (st)
      ST_NORM_OFFLINE, ST_NORM_ONLINE, ST_NORM_LIST, ST_NORM_INIT: begin
        case (ev)
          EV_BIOS_START: t = ST_NORM_ONLINE;
          EV_APP_START:  t = ST_NORM_LIST;
          EV_HEARTBEAT:  t = (st == ST_NORM_OFFLINE || st == ST_NORM_ONLINE) ?
                             ST_NORM_LIST : T_KEEP;
          EV_LIST_DONE:  t = (st == ST_NORM_LIST) ? ST_NORM_INIT : T_NO_ENTRY;
          EV_PGM_BIOS:   t = ST_BPGM_OFFLINE;
          EV_PGM_APP:    t = ST_APGM_OFFLINE;
          EV_RESET:      t = (st == ST_NORM_OFFLINE) ? T_KEEP : ST_NORM_OFFLINE;
          default:       t = T_NO_ENTRY;
        endcase
      end
      ST_BPGM_OFFLINE: t = (ev == EV_BIOS_START) ? ST_BPGM_START : T_NO_ENTRY;
      ST_BPGM_START, ST_BPGM_DATA: begin
        if (ev == EV_ACK) t = ST_BPGM_DATA;
        else if (ev == EV_NACK) t = ST_NORM_OFFLINE;
      end
      ST_BPGM_END: begin
        if (ev == EV_ACK) t = ST_BPGM_COPY;
        else if (ev == EV_NACK) t = ST_NORM_OFFLINE;
      end
      ST_BPGM_COPY:    t = (ev == EV_BIOS_START) ? ST_NORM_ONLINE : T_NO_ENTRY;
      ST_APGM_OFFLINE: t = (ev == EV_BIOS_START) ? ST_APGM_START : T_NO_ENTRY;
      ST_APGM_START, ST_APGM_DATA: begin
        if (ev == EV_ACK) t = ST_APGM_DATA;
        else if (ev == EV_NACK) t = ST_NORM_OFFLINE;
      end
      ST_APGM_END: begin
        if (ev == EV_ACK || ev == EV_NACK) t = ST_NORM_OFFLINE;
      end
      default: t = T_NO_ENTRY;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/node_management_state_machine.sv
// Channel   Direction  Handshake               Payload
// in        input      in_valid_i / in_stall_o   in_data_i   (nms_in_t)
// out       output     out_valid_o / out_stall_i out_data_o  (nms_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_idx_i, cfg_data_i
//
// One request per cycle sustained while results are not stalled; a result passes
// the input register, then the result register, before it is offered on out_valid_o.
// The state and idle counter registers update in the same cycle as the
// table lookup and limit compare, so each request sees its predecessor's state.
// Reset clears both stages, sets the node offline, idle count 0, limit 10, id 0.
// A stalled result holds; the input stalls only when both stages are full.
module node_management_state_machine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  nms_pkg::nms_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nms_pkg::nms_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);
  import nms_pkg::*;

  logic        in_vld_q;
  nms_in_t     in_q;
  logic        out_vld_q;
  nms_out_t    out_q;
  nms_out_t    res;
  logic        out_free;
  logic        step;
  logic [7:0]  timeout_q;
  logic [31:0] node_id_q;

  // Stage handshake
  assign out_free   = !out_vld_q || !out_stall_i;
  assign step       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      node_id_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        CFG_TIMEOUT: timeout_q <= cfg_data_i[7:0];
        CFG_NODE_ID: node_id_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  nms_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (in_q),
    .timeout_limit_i (timeout_q),
    .node_id_i       (node_id_q),
    .res_o           (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/nms_core.sv
module nms_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  nms_pkg::nms_in_t item_i,
  input  logic [7:0]      timeout_limit_i,
  input  logic [31:0]     node_id_i,
  output nms_pkg::nms_out_t res_o
);
  import nms_pkg::*;

  node_state_e state_q, state_d;
  logic [7:0]  idle_q, idle_d;
  logic [3:0]  tab;
  logic        is_event;
  logic        tick_drop;
  cmd_e        cmd;

  assign is_event  = (item_i.action == ACT_EVENT);
  assign tab       = nms_lookup(state_q, item_i.event_code);
  assign tick_drop = (state_q != ST_NORM_OFFLINE) && (idle_q >= timeout_limit_i);

  // Next state and idle count
  always_comb begin
    state_d = state_q;
    idle_d  = idle_q;
    if (is_event) begin
      idle_d = '0;
      if (tab == T_NO_ENTRY) begin
        state_d = ST_NORM_OFFLINE;
      end else if (tab != T_KEEP) begin
        state_d = node_state_e'(tab);
      end
    end else begin
      if (tick_drop) begin
        state_d = ST_NORM_OFFLINE;
      end
      if (idle_q != 8'hFF) begin
        idle_d = idle_q + 8'd1;
      end
    end
  end

  // Command on entering a state
  always_comb begin
    cmd = CMD_NONE;
    if (is_event) begin
      case (tab) inside
        T_NO_ENTRY: cmd = CMD_RESET;
        ST_NORM_LIST: cmd = CMD_LIST;
        ST_NORM_OFFLINE, ST_BPGM_OFFLINE, ST_APGM_OFFLINE: cmd = CMD_RESET;
        default: cmd = CMD_NONE;
      endcase
    end
  end

  // Result fields
  always_comb begin
    res_o.new_state     = state_d;
    res_o.old_state     = state_q;
    res_o.state_changed = is_event && (state_d != state_q);
    res_o.command       = cmd;
    res_o.no_transition = is_event && (tab == T_NO_ENTRY);
    res_o.timed_out     = !is_event && tick_drop;
    res_o.command_node  = (cmd != CMD_NONE) ? node_id_i : 32'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_NORM_OFFLINE;
      idle_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      idle_q  <= idle_d;
    end
  end

endmodule

>>> hdl/nms_checker.sv
module nms_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input nms_pkg::nms_out_t out_data_o
);
  import nms_pkg::*;

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Node id travels only with a command
  a_cmd_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.command == CMD_NONE |-> out_data_o.command_node == 32'd0)
    else $error("node id without command");

  // Missing table entry forces offline with a reset command
  a_no_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_transition |->
      out_data_o.new_state == ST_NORM_OFFLINE && out_data_o.command == CMD_RESET
      && !out_data_o.timed_out)
    else $error("missing entry handled wrongly");

  // Timeout drop is silent
  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.timed_out |->
      out_data_o.new_state == ST_NORM_OFFLINE && out_data_o.old_state != ST_NORM_OFFLINE
      && out_data_o.command == CMD_NONE && !out_data_o.state_changed)
    else $error("timeout result malformed");

  // Change flag agrees with the states
  a_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.state_changed |-> out_data_o.new_state != out_data_o.old_state)
    else $error("change flag without change");

endmodule

bind node_management_state_machine nms_checker u_nms_checker (.*);

>>> tb/tb_node_management_state_machine.sv
module tb_node_management_state_machine;
  timeunit 1ns;
  timeprecision 1ps;

  import nms_pkg::*;

  localparam realtime     HALF_PERIOD = 1ns;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYC  = 8;

  // Event codes with no table entry at all
  localparam logic [3:0] EV_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] EV_UNKNOWN_HI = 4'd15;

  typedef struct {
    nms_in_t  req;
    logic     typed;
    nms_out_t want;
  } dir_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  nms_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  nms_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_idx_i   = CFG_TIMEOUT;
  logic [31:0] cfg_data_i  = '0;

  // Row attached to the request currently on the bus
  logic        req_typed = 1'b0;
  nms_out_t    req_want  = '0;

  // Tracked copy of the node and its registers
  node_state_e track_state = ST_NORM_OFFLINE;
  logic [7:0]  track_idle  = '0;
  logic [7:0]  track_limit = TIMEOUT_RESET;
  logic [31:0] track_id    = '0;

  nms_out_t    pending_results[$];
  nms_out_t    predicted;
  nms_out_t    got;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned n_sent        = 0;
  int unsigned n_results     = 0;
  int unsigned n_errors      = 0;
  int unsigned n_drops       = 0;
  int unsigned n_missing     = 0;
  int unsigned n_reset_cmd   = 0;
  int unsigned n_list_cmd    = 0;
  logic [15:0] states_seen   = '0;

  node_management_state_machine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Next state for an event: a state, T_KEEP or T_NO_ENTRY
  function automatic logic [3:0] transition_for(node_state_e st, logic [3:0] code);
    logic norm;
    logic [3:0] t;
    norm = (st <= ST_NORM_INIT);
    t = T_NO_ENTRY;
    case (code)
      EV_BIOS_START: begin
        if (norm) t = ST_NORM_ONLINE;
        else if (st == ST_BPGM_OFFLINE) t = ST_BPGM_START;
        else if (st == ST_APGM_OFFLINE) t = ST_APGM_START;
        else if (st == ST_BPGM_COPY) t = ST_NORM_ONLINE;
      end
      EV_APP_START: if (norm) t = ST_NORM_LIST;
      EV_HEARTBEAT: begin
        if (st == ST_NORM_OFFLINE || st == ST_NORM_ONLINE) t = ST_NORM_LIST;
        else if (norm) t = T_KEEP;
      end
      EV_LIST_DONE: if (st == ST_NORM_LIST) t = ST_NORM_INIT;
      EV_PGM_BIOS:  if (norm) t = ST_BPGM_OFFLINE;
      EV_PGM_APP:   if (norm) t = ST_APGM_OFFLINE;
      EV_RESET: begin
        if (st == ST_NORM_OFFLINE) t = T_KEEP;
        else if (norm) t = ST_NORM_OFFLINE;
      end
      EV_ACK: begin
        if (st == ST_BPGM_START || st == ST_BPGM_DATA) t = ST_BPGM_DATA;
        else if (st == ST_BPGM_END) t = ST_BPGM_COPY;
        else if (st == ST_APGM_START || st == ST_APGM_DATA) t = ST_APGM_DATA;
        else if (st == ST_APGM_END) t = ST_NORM_OFFLINE;
      end
      EV_NACK: begin
        if (st == ST_BPGM_START || st == ST_BPGM_DATA || st == ST_BPGM_END ||
            st == ST_APGM_START || st == ST_APGM_DATA || st == ST_APGM_END)
          t = ST_NORM_OFFLINE;
      end
      default: t = T_NO_ENTRY;
    endcase
    return t;
  endfunction

  // Works out the result of one request and advances the tracked node
  function automatic nms_out_t predict_node_result(nms_in_t req);
    nms_out_t    r;
    logic [3:0]  t;
    node_state_e nxt;
    cmd_e        c;
    r = '0;
    r.old_state = track_state;
    nxt = track_state;
    c = CMD_NONE;
    if (req.action == ACT_EVENT) begin
      t = transition_for(track_state, req.event_code);
      track_idle = '0;
      if (t == T_NO_ENTRY) begin
        r.no_transition = 1'b1;
        nxt = ST_NORM_OFFLINE;
        c = CMD_RESET;
      end else if (t != T_KEEP) begin
        nxt = node_state_e'(t);
        if (nxt == ST_NORM_LIST) c = CMD_LIST;
        else if (nxt == ST_NORM_OFFLINE || nxt == ST_BPGM_OFFLINE ||
                 nxt == ST_APGM_OFFLINE) c = CMD_RESET;
      end
      r.state_changed = (nxt != track_state);
    end else begin
      // idle drop, counter saturates and is not cleared by the drop
      if (track_state != ST_NORM_OFFLINE && track_idle >= track_limit) begin
        nxt = ST_NORM_OFFLINE;
        r.timed_out = 1'b1;
      end
      if (track_idle != 8'hFF) track_idle = track_idle + 8'd1;
    end
    r.new_state = nxt;
    r.command = c;
    r.command_node = (c != CMD_NONE) ? track_id : 32'd0;
    track_state = nxt;
    return r;
  endfunction

  function automatic nms_out_t mk_result(node_state_e ns, node_state_e os, logic chg,
                                         cmd_e c, logic miss, logic tout, logic [31:0] node);
    nms_out_t r;
    r.new_state = ns;
    r.old_state = os;
    r.state_changed = chg;
    r.command = c;
    r.no_transition = miss;
    r.timed_out = tout;
    r.command_node = node;
    return r;
  endfunction

  function automatic dir_row_t mk_row(logic act, logic [3:0] code, logic typed, nms_out_t want);
    dir_row_t row;
    row.req.action = act;
    row.req.event_code = code;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  task automatic report_mismatch(string msg);
    n_errors++;
    $display("[%0t] result %0d: %s", $realtime, n_results, msg);
  endtask

  task automatic check_result(nms_out_t res, nms_out_t want);
    if (res.new_state !== want.new_state)
      report_mismatch($sformatf("new_state %0d, expected %0d", res.new_state, want.new_state));
    if (res.old_state !== want.old_state)
      report_mismatch($sformatf("old_state %0d, expected %0d", res.old_state, want.old_state));
    if (res.state_changed !== want.state_changed)
      report_mismatch($sformatf("state_changed %b, expected %b",
                                res.state_changed, want.state_changed));
    if (res.command !== want.command)
      report_mismatch($sformatf("command %0d, expected %0d", res.command, want.command));
    if (res.no_transition !== want.no_transition)
      report_mismatch($sformatf("no_transition %b, expected %b",
                                res.no_transition, want.no_transition));
    if (res.timed_out !== want.timed_out)
      report_mismatch($sformatf("timed_out %b, expected %b", res.timed_out, want.timed_out));
    if (res.command_node !== want.command_node)
      report_mismatch($sformatf("command_node %h, expected %h",
                                res.command_node, want.command_node));
  endtask

  // Request accepted: predict and queue the result
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predicted = predict_node_result(in_data_i);
      pending_results.push_back(req_typed ? req_want : predicted);
    end
  end

  // Result accepted: compare with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = out_data_o;
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("result arrived with nothing pending");
      end else begin
        check_result(got, pending_results.pop_front());
      end
      if (got.timed_out) n_drops++;
      if (got.no_transition) n_missing++;
      if (got.command == CMD_RESET) n_reset_cmd++;
      if (got.command == CMD_LIST) n_list_cmd++;
      states_seen[got.new_state] = 1'b1;
    end
  end

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("stalled for %0d cycles with %0d results pending",
               QUIET_LIMIT, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Puts one request on the bus, with random gaps, and waits for it to be taken
  task automatic issue(nms_in_t req, logic typed, nms_out_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    req_typed  <= typed;
    req_want   <= want;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic send_req(logic act, logic [3:0] code);
    nms_in_t req;
    req.action = act;
    req.event_code = code;
    issue(req, 1'b0, '0);
  endtask

  // Holds off new requests until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_TIMEOUT) track_limit = data[7:0];
    else track_id = data;
  endtask

  // Timeout with random upper bits, which the block must ignore
  task automatic set_limit(logic [7:0] lim);
    write_reg(CFG_TIMEOUT, ($urandom() & 32'hFFFF_FF00) | {24'd0, lim});
  endtask

  // One random stretch of traffic: mostly proper flows, some noise
  task automatic random_burst();
    int unsigned pick;
    int unsigned n;
    int unsigned cap;
    logic [3:0]  rnd_code;
    logic        use_app;
    pick = $urandom_range(99);
    n = $urandom_range(5);
    rnd_code = 4'($urandom_range(15));
    use_app = 1'($urandom_range(1));
    cap = (track_limit < 12) ? track_limit + 3 : 14;
    if (pick < 3) wait_drained();
    if (pick < 12) begin
      // noise: any action, any code
      repeat (n + 1) send_req(1'($urandom_range(1)), 4'($urandom_range(15)));
    end else if (pick < 32) begin
      // normal bring-up: online, listing, initialised
      send_req(ACT_EVENT, $urandom_range(1) ? EV_BIOS_START : EV_RESET);
      send_req(ACT_EVENT, $urandom_range(1) ? EV_APP_START : EV_HEARTBEAT);
      repeat ($urandom_range(2)) send_req(ACT_EVENT, EV_HEARTBEAT);
      send_req(ACT_EVENT, EV_LIST_DONE);
      repeat ($urandom_range(3))
        send_req(ACT_EVENT, ($urandom_range(3) == 0) ? EV_APP_START : EV_HEARTBEAT);
      if ($urandom_range(3) == 0) send_req(ACT_EVENT, EV_RESET);
    end else if (pick < 62) begin
      // programming flow, sometimes broken by a stray event
      if ($urandom_range(1)) send_req(ACT_EVENT, EV_RESET);
      send_req(ACT_EVENT, use_app ? EV_PGM_APP : EV_PGM_BIOS);
      send_req(ACT_EVENT, EV_BIOS_START);
      repeat (n) begin
        if ($urandom_range(9) == 0) send_req(ACT_EVENT, 4'($urandom_range(15)));
        else if ($urandom_range(4) == 0) send_req(ACT_TICK, 4'($urandom_range(15)));
        else send_req(ACT_EVENT, EV_ACK);
      end
      send_req(ACT_EVENT, ($urandom_range(4) == 0) ? rnd_code : EV_NACK);
    end else if (pick < 82) begin
      // idle run, long enough to drop the node when the limit is low
      repeat ($urandom_range(1, cap)) send_req(ACT_TICK, 4'($urandom_range(15)));
    end else begin
      // keep-alive: up to limit + 1 ticks (at most 12), then a heartbeat
      repeat (n + 1) begin
        repeat ($urandom_range(cap - 2)) send_req(ACT_TICK, 4'($urandom_range(15)));
        send_req(ACT_EVENT, EV_HEARTBEAT);
      end
    end
  endtask

  initial begin
    dir_row_t    dir_tab[$];
    nms_out_t    quiet_off;
    nms_out_t    missing_off;
    int unsigned target;

    quiet_off   = mk_result(ST_NORM_OFFLINE, ST_NORM_OFFLINE, 1'b0, CMD_NONE, 1'b0, 1'b0, '0);
    missing_off = mk_result(ST_NORM_OFFLINE, ST_NORM_OFFLINE, 1'b0, CMD_RESET, 1'b1, 1'b0,
                            32'hFFFF_FFFF);

    // Directed walk through every flow, limit 1 and an all-ones node id
    dir_tab.push_back(mk_row(ACT_TICK,  EV_BIOS_START, 1'b1, quiet_off));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_RESET,      1'b1, quiet_off));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_ACK,        1'b1, missing_off));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_UNKNOWN_HI, 1'b1, missing_off));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_BIOS_START, 1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_HEARTBEAT,  1'b0, '0));
    // list re-entered from list still asks for the module list
    dir_tab.push_back(mk_row(ACT_EVENT, EV_APP_START,  1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_HEARTBEAT,  1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_LIST_DONE,  1'b0, '0));
    dir_tab.push_back(mk_row(ACT_TICK,  EV_UNKNOWN_HI, 1'b0, '0));
    dir_tab.push_back(mk_row(ACT_TICK,  EV_BIOS_START, 1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_PGM_BIOS,   1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_BIOS_START, 1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_ACK,        1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_ACK,        1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_NACK,       1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_PGM_APP,    1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_BIOS_START, 1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_ACK,        1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_NACK,       1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_APP_START,  1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_LIST_DONE,  1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_RESET,      1'b0, '0));
    dir_tab.push_back(mk_row(ACT_EVENT, EV_UNKNOWN_LO, 1'b1, missing_off));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender 26 %, receiver 78 %
    send_idle_pct = 26;
    recv_idle_pct = 78;
    set_limit(8'd1);
    write_reg(CFG_NODE_ID, 32'hFFFF_FFFF);
    foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

    // highest limit: only a saturated idle counter drops the node
    set_limit(8'd255);
    write_reg(CFG_NODE_ID, $urandom());
    send_req(ACT_EVENT, EV_BIOS_START);
    repeat (262) send_req(ACT_TICK, 4'($urandom_range(15)));
    target = n_sent + 60;
    while (n_sent < target) random_burst();

    // sender 78 %, receiver 26 %, small limits
    send_idle_pct = 78;
    recv_idle_pct = 26;
    set_limit(8'($urandom_range(2, 12)));
    write_reg(CFG_NODE_ID, 32'd0);
    target = n_sent + 150;
    while (n_sent < target) random_burst();
    set_limit(8'd1);
    write_reg(CFG_NODE_ID, $urandom());
    target = n_sent + 150;
    while (n_sent < target) random_burst();

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limit(TIMEOUT_RESET);
    write_reg(CFG_NODE_ID, $urandom());
    target = n_sent + 300;
    while (n_sent < target) random_burst();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));

    $display("%0d requests, %0d results checked, %0d mismatches",
             n_sent, n_results, n_errors);
    $display("%0d idle drops, %0d missing entries, %0d resets, %0d list requests, %0d states",
             n_drops, n_missing, n_reset_cmd, n_list_cmd, $countones(states_seen));
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
